@@ hw/rtl/ssa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants for the sorted set unit: operation codes,
// status codes and the result word passed from the engine to the output stage.
// ----------------------------------------------------------------------------
package ssa_pkg;

    typedef enum logic [2:0] {
        FN_INSERT    = 3'd0,
        FN_REMOVE    = 3'd1,
        FN_SEARCH    = 3'd2,
        FN_AGGREGATE = 3'd3,
        FN_REPLACE   = 3'd4
    } t_func;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOCHANGE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic signed [31:0] TRIPLE_LIMIT = 32'sd60;
    localparam logic [31:0]        INV3         = 32'hAAAA_AAAB;
    localparam logic [31:0]        THIRD_MAX    = 32'h5555_5555;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] even_sum;
        logic [31:0] triple_product;
    } t_result;

endpackage
`default_nettype wire

@@ hw/rtl/ssa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_ram
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hw/rtl/ssa_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_engine
// Operation sequencer: scans the store for the lower bound, shifts entries
// up or down through the RAM one word per cycle, and walks the store for the
// even sum and the product of small multiples of three.
// ----------------------------------------------------------------------------
module ssa_engine #(
    parameter int  CAPACITY = 64,
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [2:0]      i_func,
    input  wire logic [31:0]     i_key,
    input  wire logic [31:0]     i_new,
    output logic                 o_idle,
    output logic                 o_res_valid,
    input  wire logic            i_res_take,
    output ssa_pkg::t_result     o_result,
    output logic [CW-1:0]        o_count,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [31:0]          o_wdata,
    output logic [AW-1:0]        o_raddr,
    input  wire logic [31:0]     i_rdata
);

    import ssa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHUP,
        S_PUT,
        S_SHDN,
        S_RMEND,
        S_AGG,
        S_DONE
    } t_state;

    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE        = CW'(1);

    function automatic logic is_triple(input logic [31:0] v);
        logic [31:0] mag;
        logic [31:0] scaled;
        mag    = v[31] ? (32'd0 - v) : v;
        scaled = mag * INV3;
        return (v != 32'd0) && ($signed(v) < TRIPLE_LIMIT) && (scaled <= THIRD_MAX);
    endfunction

    t_state        r_state;
    t_func         r_func;
    logic [31:0]   r_tgt;
    logic [31:0]   r_nv;
    logic          r_second;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_chk;
    logic [CW-1:0] r_pos;
    logic          r_pend;
    logic          r_iss;
    logic          r_hit;
    logic [1:0]    r_status;
    logic          r_found;
    logic [31:0]   r_sum;
    logic [31:0]   r_prod;
    logic          r_a_vld;
    logic [31:0]   r_a_val;
    logic          r_a_even;
    logic          r_a_trip;

    logic          iss_scan;
    logic          less;
    logic [CW-1:0] chk_inc;
    logic [CW-1:0] chk_dec;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] cnt_dec;
    logic [31:0]   sum_add;
    logic [31:0]   mul_op;

    assign iss_scan = (r_ptr < r_count);
    assign less     = ($signed(i_rdata) < $signed(r_tgt));
    assign chk_inc  = r_chk + ONE;
    assign chk_dec  = r_chk - ONE;
    assign pos_inc  = r_pos + ONE;
    assign cnt_dec  = r_count - ONE;
    assign sum_add  = r_a_even ? r_a_val : 32'd0;
    assign mul_op   = r_a_trip ? r_a_val : 32'd1;

    always_comb begin
        o_raddr = r_ptr[AW-1:0];
        o_we    = 1'b0;
        o_waddr = chk_inc[AW-1:0];
        o_wdata = i_rdata;
        unique case (r_state)
            S_SHUP: begin
                o_we    = r_pend;
                o_waddr = chk_inc[AW-1:0];
            end
            S_SHDN: begin
                o_we    = r_pend;
                o_waddr = chk_dec[AW-1:0];
            end
            S_PUT: begin
                o_we    = 1'b1;
                o_waddr = r_pos[AW-1:0];
                o_wdata = r_tgt;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_iss   <= 1'b0;
            r_a_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_func   <= t_func'(i_func);
                        r_tgt    <= i_key;
                        r_nv     <= i_new;
                        r_second <= 1'b0;
                        r_ptr    <= '0;
                        r_pend   <= 1'b0;
                        r_a_vld  <= 1'b0;
                        r_status <= ST_NOCHANGE;
                        r_found  <= 1'b0;
                        r_sum    <= '0;
                        r_prod   <= '0;
                        unique case (t_func'(i_func))
                            FN_INSERT, FN_REMOVE, FN_SEARCH, FN_REPLACE: begin
                                r_state <= S_SCAN;
                            end
                            FN_AGGREGATE: begin
                                r_status <= ST_DONE;
                                r_prod   <= 32'd1;
                                r_state  <= S_AGG;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_pend <= iss_scan;
                    r_chk  <= r_ptr;
                    if (iss_scan) begin
                        r_ptr <= r_ptr + ONE;
                    end
                    priority if (r_pend && !less) begin
                        r_pos   <= r_chk;
                        r_hit   <= (i_rdata == r_tgt);
                        r_pend  <= 1'b0;
                        r_state <= S_DECIDE;
                    end else if ((r_pend && chk_inc == r_count) || (!r_pend && !iss_scan)) begin
                        r_pos   <= r_count;
                        r_hit   <= 1'b0;
                        r_pend  <= 1'b0;
                        r_state <= S_DECIDE;
                    end else begin
                        r_hit <= 1'b0;
                    end
                end
                S_DECIDE: begin
                    r_pend <= 1'b0;
                    priority if (r_second || r_func == FN_INSERT) begin
                        priority if (r_hit) begin
                            r_status <= ST_NOCHANGE;
                            r_state  <= S_DONE;
                        end else if (r_count == FULL_COUNT) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else if (r_pos < r_count) begin
                            r_ptr   <= cnt_dec;
                            r_iss   <= 1'b1;
                            r_state <= S_SHUP;
                        end else begin
                            r_state <= S_PUT;
                        end
                    end else if (r_func == FN_SEARCH) begin
                        if (r_hit) begin
                            r_status <= ST_DONE;
                            r_found  <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        priority if (!r_hit) begin
                            r_state <= S_DONE;
                        end else if (pos_inc < r_count) begin
                            r_found <= 1'b1;
                            r_ptr   <= pos_inc;
                            r_iss   <= 1'b1;
                            r_state <= S_SHDN;
                        end else begin
                            r_found <= 1'b1;
                            r_state <= S_RMEND;
                        end
                    end
                end
                S_SHUP: begin
                    if (r_iss) begin
                        r_chk  <= r_ptr;
                        r_pend <= 1'b1;
                        if (r_ptr == r_pos) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_ptr <= r_ptr - ONE;
                        end
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && r_chk == r_pos) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_count  <= r_count + ONE;
                    r_status <= ST_DONE;
                    r_state  <= S_DONE;
                end
                S_SHDN: begin
                    if (r_iss) begin
                        r_chk  <= r_ptr;
                        r_pend <= 1'b1;
                        if (r_ptr == cnt_dec) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_ptr <= r_ptr + ONE;
                        end
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && r_chk == cnt_dec) begin
                        r_state <= S_RMEND;
                    end
                end
                S_RMEND: begin
                    r_count <= cnt_dec;
                    r_pend  <= 1'b0;
                    if (r_func == FN_REPLACE) begin
                        r_second <= 1'b1;
                        r_tgt    <= r_nv;
                        r_ptr    <= '0;
                        r_state  <= S_SCAN;
                    end else begin
                        r_status <= ST_DONE;
                        r_state  <= S_DONE;
                    end
                end
                S_AGG: begin
                    r_pend <= iss_scan;
                    if (iss_scan) begin
                        r_ptr <= r_ptr + ONE;
                    end
                    r_a_vld  <= r_pend;
                    r_a_val  <= i_rdata;
                    r_a_even <= ~i_rdata[0];
                    r_a_trip <= is_triple(i_rdata);
                    if (r_a_vld) begin
                        r_sum  <= r_sum + sum_add;
                        r_prod <= r_prod * mul_op;
                    end
                    if (!iss_scan && !r_pend && !r_a_vld) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_count     = r_count;

    always_comb begin
        o_result.status         = r_status;
        o_result.found          = r_found;
        o_result.even_sum       = r_sum;
        o_result.triple_product = r_prod;
    end

endmodule
`default_nettype wire

@@ hw/rtl/sorted_set_with_aggregates_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_with_aggregates_unit
// Ascending set of signed 32-bit words held in one RAM, with insert, remove,
// search, replace and an aggregate walk (even sum, product of nonzero multiples of 3 below 60).
// ----------------------------------------------------------------------------
//  channel  valid        stall        word
//  in       i_in_valid   o_in_stall   i_func, i_key_value, i_new_value
//  out      o_out_valid  i_out_stall  o_status, o_found, o_entry_count,
//                                     o_even_sum, o_triple_product
//
//  One word at a time; the RAM walk sets the time, which grows with the
//  number of entries (replace walks the store twice). The RAM reads and
//  writes one entry per cycle. No clearing pass after reset; the entry count
//  starts at zero.
//  A finished word sits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module sorted_set_with_aggregates_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_func,
    input  wire logic signed [31:0] i_key_value,
    input  wire logic signed [31:0] i_new_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic                    o_found,
    output logic [6:0]              o_entry_count,
    output logic signed [31:0]      o_even_sum,
    output logic signed [31:0]      o_triple_product
);

    import ssa_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          in_acc;
    logic          eng_idle;
    logic          eng_res_valid;
    logic          res_take;
    t_result       eng_result;
    logic [CW-1:0] eng_count;
    logic [CW+6:0] cnt_ext;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    logic          r_out_valid;
    logic [1:0]    r_status;
    logic          r_found;
    logic [6:0]    r_entry_count;
    logic [31:0]   r_even_sum;
    logic [31:0]   r_triple_product;

    assign o_in_stall = ~eng_idle;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign res_take   = ~r_out_valid | ~i_out_stall;
    assign cnt_ext    = {7'd0, eng_count};

    ssa_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc),
        .i_func      (i_func),
        .i_key       (i_key_value),
        .i_new       (i_new_value),
        .o_idle      (eng_idle),
        .o_res_valid (eng_res_valid),
        .i_res_take  (res_take),
        .o_result    (eng_result),
        .o_count     (eng_count),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    ssa_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_valid && res_take) begin
            r_status         <= eng_result.status;
            r_found          <= eng_result.found;
            r_entry_count    <= cnt_ext[6:0];
            r_even_sum       <= eng_result.even_sum;
            r_triple_product <= eng_result.triple_product;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found          = r_found;
    assign o_entry_count    = r_entry_count;
    assign o_even_sum       = r_even_sum;
    assign o_triple_product = r_triple_product;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && in_acc) |=> o_in_stall)
        else $error("input not stalled while an operation runs");

    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> !o_found)
        else $error("full status with found set");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && eng_res_valid && res_take) |=> o_out_valid)
        else $error("finished result not loaded into output register");
`endif

endmodule
`default_nettype wire

@@ test/ssa_reply_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_reply_checker
// Watches both channels of the sorted set unit. Every accepted command word
// is run through a local sorted-set model that yields the reply the unit
// must give. Every accepted reply word is compared field by field with the
// oldest pending prediction. Mismatches and unexpected replies are counted.
// ----------------------------------------------------------------------------
module ssa_reply_checker #(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [2:0]         i_func,
    input  wire logic signed [31:0] i_key_value,
    input  wire logic signed [31:0] i_new_value,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [1:0]         i_status,
    input  wire logic               i_found,
    input  wire logic [6:0]         i_entry_count,
    input  wire logic signed [31:0] i_even_sum,
    input  wire logic signed [31:0] i_triple_product,
    output int                      o_fail_count,
    output int                      o_pending
);
    import ssa_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [6:0]  entry_count;
        logic [31:0] even_sum;
        logic [31:0] triple_product;
    } t_set_reply;

    logic signed [31:0] set_entries [CAPACITY];
    int                 set_size = 0;
    t_set_reply         reply_queue [$];
    t_set_reply         oldest_reply;
    int                 fail_count = 0;
    int                 pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // first slot whose entry is not below v
    function automatic int lower_index(logic signed [31:0] v);
        int k;
        k = 0;
        while (k < set_size && set_entries[k] < v)
            k++;
        return k;
    endfunction

    function automatic bit holds_value(logic signed [31:0] v);
        int k;
        k = lower_index(v);
        return k < set_size && set_entries[k] == v;
    endfunction

    function automatic logic [1:0] add_entry(logic signed [31:0] v);
        int k;
        int j;
        k = lower_index(v);
        if (k < set_size && set_entries[k] == v)
            return ST_NOCHANGE;
        if (set_size >= CAPACITY)
            return ST_FULL;
        for (j = set_size; j > k; j--)
            set_entries[j] = set_entries[j - 1];
        set_entries[k] = v;
        set_size++;
        return ST_DONE;
    endfunction

    function automatic bit drop_entry(logic signed [31:0] v);
        int k;
        int j;
        k = lower_index(v);
        if (!(k < set_size && set_entries[k] == v))
            return 1'b0;
        for (j = k; j < set_size - 1; j++)
            set_entries[j] = set_entries[j + 1];
        set_size--;
        return 1'b1;
    endfunction

    function automatic bit is_triple_term(logic signed [31:0] v);
        logic [31:0] mag;
        if (v == 0 || v >= TRIPLE_LIMIT)
            return 1'b0;
        mag = v[31] ? (32'd0 - $unsigned(v)) : $unsigned(v);
        return (mag % 32'd3) == 32'd0;
    endfunction

    function automatic t_set_reply predict_set_reply(logic [2:0] func,
                                                     logic signed [31:0] key,
                                                     logic signed [31:0] repl);
        t_set_reply  r;
        int          k;
        logic [31:0] sum;
        logic [31:0] prod;
        r = '0;
        r.status = ST_NOCHANGE;
        case (func)
            FN_INSERT: r.status = add_entry(key);
            FN_REMOVE: begin
                if (drop_entry(key)) begin
                    r.status = ST_DONE;
                    r.found  = 1'b1;
                end
            end
            FN_SEARCH: begin
                if (holds_value(key)) begin
                    r.status = ST_DONE;
                    r.found  = 1'b1;
                end
            end
            FN_AGGREGATE: begin
                sum  = 32'd0;
                prod = 32'd1;
                for (k = 0; k < set_size; k++) begin
                    if (!set_entries[k][0])
                        sum = sum + set_entries[k];
                    if (is_triple_term(set_entries[k]))
                        prod = prod * set_entries[k];
                end
                r.status         = ST_DONE;
                r.even_sum       = sum;
                r.triple_product = prod;
            end
            FN_REPLACE: begin
                if (drop_entry(key)) begin
                    r.found  = 1'b1;
                    r.status = add_entry(repl);
                end
            end
            default: ;
        endcase
        r.entry_count = 7'(set_size);
        return r;
    endfunction

    task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (reply_queue.size() == 0) begin
                    $display("%0t: reply word with none expected, status %0d count %0d",
                             $time, i_status, i_entry_count);
                    fail_count++;
                end else begin
                    oldest_reply = reply_queue.pop_front();
                    check_field("status", oldest_reply.status, i_status);
                    check_field("found", oldest_reply.found, i_found);
                    check_field("entry_count", oldest_reply.entry_count, i_entry_count);
                    check_field("even_sum", oldest_reply.even_sum, i_even_sum);
                    check_field("triple_product", oldest_reply.triple_product,
                                i_triple_product);
                end
            end
            if (i_in_valid && !i_in_stall)
                reply_queue.push_back(predict_set_reply(i_func, i_key_value, i_new_value));
            pending_count = reply_queue.size();
        end
    end

endmodule

@@ test/tb_sorted_set_with_aggregates_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_set_with_aggregates_unit
// Drives command words into the sorted set unit: a directed pass over the
// value extremes, every operation and the corner cases, then rounds that
// fill the set past full and drain it again with random content. Both
// channels see random gaps; the reply checker decides pass or fail.
// ----------------------------------------------------------------------------
module tb_sorted_set_with_aggregates_unit;
    import ssa_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int POOL_SIZE      = 72;
    localparam int ROUNDS         = 3;
    localparam int FILL_ITEMS     = 130;
    localparam int DRAIN_ITEMS    = 120;
    localparam int SETTLE_CYCLES  = 4 * CAPACITY + 40;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [2:0]         FN_SPARE_FIRST = 3'd5;
    localparam logic [2:0]         FN_SPARE_LAST  = 3'd7;
    localparam logic signed [31:0] VAL_MIN        = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX        = 32'sh7FFF_FFFF;

    logic               i_clk;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic [2:0]         i_func           = FN_SEARCH;
    logic signed [31:0] i_key_value      = '0;
    logic signed [31:0] i_new_value      = '0;
    logic               i_out_stall      = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic               o_found;
    logic [6:0]         o_entry_count;
    logic signed [31:0] o_even_sum;
    logic signed [31:0] o_triple_product;

    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    int                 cycle_count = 0;
    int                 stall_left  = 0;
    bit                 calm        = 1'b0;
    logic signed [31:0] key_pool [POOL_SIZE];

    sorted_set_with_aggregates_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_key_value     (i_key_value),
        .i_new_value     (i_new_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_entry_count   (o_entry_count),
        .o_even_sum      (o_even_sum),
        .o_triple_product(o_triple_product)
    );

    ssa_reply_checker #(
        .CAPACITY(CAPACITY)
    ) reply_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_key_value     (i_key_value),
        .i_new_value     (i_new_value),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_found         (o_found),
        .i_entry_count   (o_entry_count),
        .i_even_sum      (o_even_sum),
        .i_triple_product(o_triple_product),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // calm windows: no gaps on either side
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 500 == 0)
            calm <= ($urandom_range(0, 4) == 0);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 140)) - 32'd70;
            1: begin
                if ($urandom_range(0, 1))
                    return VAL_MIN + 32'($urandom_range(0, 3));
                return VAL_MAX - 32'($urandom_range(0, 3));
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pool_word();
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [2:0] pick_func(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
        if (r < 10)
            return FN_AGGREGATE;
        if (r < 20)
            return FN_SEARCH;
        if (r < 30)
            return FN_REPLACE;
        if (filling)
            return (r < 92) ? FN_INSERT : FN_REMOVE;
        return (r < 34) ? FN_INSERT : FN_REMOVE;
    endfunction

    task automatic issue_word(logic [2:0] func, logic signed [31:0] key,
                              logic signed [31:0] repl);
        int gap;
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_key_value <= key;
        i_new_value <= repl;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int          round;
        int          step;
        int          fill_ptr;
        int          drain_ptr;
        int          k;
        bit          filling;
        logic [2:0]  func;
        logic signed [31:0] key;
        logic signed [31:0] repl;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty set, absent keys
        issue_word(FN_SEARCH, 32'sd5, random_word());
        issue_word(FN_REMOVE, 32'sd5, random_word());
        issue_word(FN_REPLACE, 32'sd5, 32'sd6);
        // extremes, zero, triple boundaries, duplicate
        issue_word(FN_INSERT, VAL_MIN, random_word());
        issue_word(FN_INSERT, VAL_MAX, random_word());
        issue_word(FN_INSERT, 32'sd0, random_word());
        issue_word(FN_INSERT, 32'sd57, random_word());
        issue_word(FN_INSERT, 32'sd60, random_word());
        issue_word(FN_INSERT, -32'sd60, random_word());
        issue_word(FN_INSERT, 32'sd0, random_word());
        issue_word(FN_SEARCH, VAL_MAX, random_word());
        issue_word(FN_AGGREGATE, random_word(), random_word());
        // replace onto a present value, onto a new one, onto itself
        issue_word(FN_REPLACE, 32'sd57, 32'sd0);
        issue_word(FN_REPLACE, 32'sd0, 32'sd42);
        issue_word(FN_REPLACE, 32'sd42, 32'sd42);
        for (k = FN_SPARE_FIRST; k <= FN_SPARE_LAST; k++)
            issue_word(3'(k), random_word(), random_word());
        // drain to empty
        issue_word(FN_REMOVE, VAL_MIN, random_word());
        issue_word(FN_REMOVE, VAL_MAX, random_word());
        issue_word(FN_REMOVE, 32'sd60, random_word());
        issue_word(FN_REMOVE, -32'sd60, random_word());
        issue_word(FN_REMOVE, 32'sd42, random_word());
        issue_word(FN_AGGREGATE, random_word(), random_word());

        for (round = 0; round < ROUNDS; round++) begin
            for (k = 0; k < POOL_SIZE; k++)
                key_pool[k] = random_word();
            fill_ptr  = 0;
            drain_ptr = 0;
            for (step = 0; step < FILL_ITEMS + DRAIN_ITEMS; step++) begin
                filling = step < FILL_ITEMS;
                func    = pick_func(filling);
                key     = ($urandom_range(0, 9) == 0) ? random_word() : pool_word();
                repl    = random_word();
                if (func == FN_INSERT && filling && $urandom_range(0, 4) != 0) begin
                    key      = key_pool[fill_ptr % POOL_SIZE];
                    fill_ptr = fill_ptr + 1;
                end else if (func == FN_REMOVE && !filling) begin
                    key       = key_pool[drain_ptr % POOL_SIZE];
                    drain_ptr = drain_ptr + 1;
                end else if (func == FN_REPLACE && $urandom_range(0, 1)) begin
                    repl = pool_word();
                end
                issue_word(func, key, repl);
            end
            // hold off until every reply of the round is back
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0)
                @(posedge i_clk);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_ram.sv
hw/rtl/ssa_engine.sv
hw/rtl/sorted_set_with_aggregates_unit.sv
test/ssa_reply_checker.sv
test/tb_sorted_set_with_aggregates_unit.sv
